>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk, reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset
`define SBR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check a consequent whenever the antecedent holds
`define SBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

>>> hw/rtl/sbr_pkg.sv
// ---------------------------------------------------------------------------
// sbr_pkg
// Types, constants and the CRC-16 byte update shared by the packet receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  // Raw byte position wraps here; raw index is 7 bits wide
  localparam logic [7:0] INDEX_WRAP = 8'd127;

  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [7:0]  HDR_BYTE0  = 8'hFF;
  localparam logic [7:0]  HDR_BYTE2  = 8'hFD;
  localparam logic [7:0]  HDR_BYTE3  = 8'h00;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT  = 8'd1;
  localparam logic [15:0] RX_TIMEOUT_RST = 16'd500;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_CRC_BAD  = 3'd2,
    EV_REJECT   = 3'd3,
    EV_TIMEOUT  = 3'd4
  } event_t;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_t      event_res;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic [7:0]  instruction;
    logic [15:0] packet_length;
  } result_t;

  // One byte of CRC-16, MSB first, not reflected
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // CRC after the first header byte, and after FF FF FD
  localparam logic [15:0] CRC_AFTER_FF  = crc_step(16'h0000, HDR_BYTE0);
  localparam logic [15:0] CRC_AFTER_HDR =
    crc_step(crc_step(CRC_AFTER_FF, HDR_BYTE0), HDR_BYTE2);

endpackage

`default_nettype wire

>>> hw/rtl/sbr_core.sv
// ---------------------------------------------------------------------------
// sbr_core
// Packet state machine: header hunt, ID check, length, instruction,
// parameters, CRC compare and idle timeout. One word per fire strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module sbr_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_fire,
  input  wire sbr_pkg::item_t  item,
  input  wire logic [7:0]      expected_id,
  input  wire logic [15:0]     rx_timeout,
  output sbr_pkg::result_t     result
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_ID     = 3'd2,
    PH_LENGTH = 3'd3,
    PH_INSTR  = 3'd4,
    PH_PARAMS = 3'd5,
    PH_CRC    = 3'd6
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [1:0]  sub_r,     sub_nxt;
  logic [6:0]  raw_idx_r, raw_idx_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [7:0]  pre_crc_r, pre_crc_nxt;
  logic [15:0] crc_r,     crc_nxt;
  logic [7:0]  crc_lo_r,  crc_lo_nxt;
  logic [15:0] idle_r,    idle_nxt;
  logic [7:0]  instr_r,   instr_nxt;

  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [7:0]  raw_inc;
  logic [6:0]  raw_wrap;
  logic [15:0] len_full;
  logic [16:0] len_plus;
  logic        len_bad;
  logic [15:0] idle_inc;
  sbr_pkg::event_t ev;
  logic        pv;
  logic [7:0]  pb;
  logic [6:0]  pi;

  assign b        = item.rx_byte;
  assign crc_upd  = sbr_pkg::crc_step(crc_r, b);
  assign raw_inc  = {1'b0, raw_idx_r} + 8'd1;
  assign raw_wrap = (raw_inc >= sbr_pkg::INDEX_WRAP) ? 7'd0 : raw_inc[6:0];
  assign len_full = {b, len_r[7:0]};
  assign len_plus = {1'b0, len_full} + 17'd5;
  assign len_bad  = (len_full < 16'd3) ||
                    (len_plus > ({9'd0, sbr_pkg::INDEX_WRAP} - 17'd1));
  assign idle_inc = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;

  // Next state and result for the word at the input
  always_comb begin
    phase_nxt   = phase_r;
    sub_nxt     = sub_r;
    raw_idx_nxt = raw_idx_r;
    len_nxt     = len_r;
    pre_crc_nxt = pre_crc_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    idle_nxt    = idle_r;
    instr_nxt   = instr_r;
    ev          = sbr_pkg::EV_NONE;
    pv          = 1'b0;
    pb          = 8'd0;
    pi          = 7'd0;

    if (item.action == sbr_pkg::ACT_TICK) begin
      // Count idle ticks inside a packet, drop it once past the timeout
      if (phase_r != PH_HUNT) begin
        if (idle_inc > rx_timeout) begin
          idle_nxt  = 16'd0;
          phase_nxt = PH_HUNT;
          sub_nxt   = 2'd0;
          ev        = sbr_pkg::EV_TIMEOUT;
        end else begin
          idle_nxt  = idle_inc;
        end
      end
    end else begin
      raw_idx_nxt = raw_wrap;
      idle_nxt    = 16'd0;
      case (phase_r)
        PH_HEADER: begin
          if (sub_r != 2'd3) begin
            crc_nxt = crc_upd;
            sub_nxt = sub_r + 2'd1;
          end else if (crc_r == sbr_pkg::CRC_AFTER_HDR && b == sbr_pkg::HDR_BYTE3) begin
            crc_nxt   = crc_upd;
            phase_nxt = PH_ID;
            sub_nxt   = 2'd0;
          end else begin
            phase_nxt = PH_HUNT;
            sub_nxt   = 2'd0;
            ev        = sbr_pkg::EV_REJECT;
          end
        end
        PH_ID: begin
          if (b == expected_id) begin
            crc_nxt   = crc_upd;
            phase_nxt = PH_LENGTH;
          end else begin
            ev        = sbr_pkg::EV_REJECT;
            phase_nxt = PH_HUNT;
          end
          sub_nxt = 2'd0;
        end
        PH_LENGTH: begin
          crc_nxt = crc_upd;
          if (sub_r == 2'd0) begin
            len_nxt = {8'd0, b};
            sub_nxt = 2'd1;
          end else begin
            len_nxt     = len_full;
            pre_crc_nxt = len_bad ? 8'hFF : len_plus[7:0];
            phase_nxt   = PH_INSTR;
            sub_nxt     = 2'd0;
          end
        end
        PH_INSTR: begin
          crc_nxt   = crc_upd;
          instr_nxt = b;
          phase_nxt = (len_r == 16'd3) ? PH_CRC : PH_PARAMS;
          sub_nxt   = 2'd0;
        end
        PH_PARAMS: begin
          crc_nxt = crc_upd;
          pv      = 1'b1;
          pb      = b;
          pi      = raw_idx_r;
          if ({1'b0, raw_wrap} == pre_crc_r) begin
            phase_nxt = PH_CRC;
            sub_nxt   = 2'd0;
          end
        end
        PH_CRC: begin
          if (sub_r == 2'd0) begin
            crc_lo_nxt = b;
            sub_nxt    = 2'd1;
          end else begin
            ev        = ({b, crc_lo_r} == crc_r) ? sbr_pkg::EV_GOOD : sbr_pkg::EV_CRC_BAD;
            phase_nxt = PH_HUNT;
            sub_nxt   = 2'd0;
          end
        end
        default: begin
          // Hunt: a first header byte opens a packet
          phase_nxt = PH_HUNT;
          if (b == sbr_pkg::HDR_BYTE0) begin
            phase_nxt   = PH_HEADER;
            sub_nxt     = 2'd1;
            raw_idx_nxt = 7'd1;
            crc_nxt     = sbr_pkg::CRC_AFTER_FF;
          end
        end
      endcase
    end

    result.event_res     = ev;
    result.payload_valid = pv;
    result.payload_byte  = pb;
    result.payload_index = pi;
    result.instruction   = instr_nxt;
    result.packet_length = len_nxt;
  end

  // Hold state; advance on each fired word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      sub_r     <= 2'd0;
      raw_idx_r <= 7'd0;
      len_r     <= 16'd0;
      pre_crc_r <= 8'd0;
      crc_r     <= 16'd0;
      crc_lo_r  <= 8'd0;
      idle_r    <= 16'd0;
      instr_r   <= 8'd0;
    end else if (item_fire) begin
      phase_r   <= phase_nxt;
      sub_r     <= sub_nxt;
      raw_idx_r <= raw_idx_nxt;
      len_r     <= len_nxt;
      pre_crc_r <= pre_crc_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
      idle_r    <= idle_nxt;
      instr_r   <= instr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/servo_bus_packet_receiver.sv
// An accepted word waits in the input register until its result word is loaded.
// Throughput: one word per cycle unless out_stall holds; the CRC byte update
// and phase move sit in one stage between the input and result registers.
// Reset (rst_n low, synchronous) empties both registers, returns the receiver to
// header hunt, and sets expected_id to 0 and rx_timeout to 500.
// ---------------------------------------------------------------------------
// servo_bus_packet_receiver
// Bus packet receiver with header hunt, ID filter, CRC-16 check and timeout.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_bus_packet_receiver (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_event_res,
  output logic                                out_payload_valid,
  output logic [7:0]                          out_payload_byte,
  output logic [6:0]                          out_payload_index,
  output logic [7:0]                          out_instruction,
  output logic [15:0]                         out_packet_length,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbr_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  logic             s1_valid_r, s1_valid_nxt;
  sbr_pkg::item_t   s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  sbr_pkg::result_t out_res_r;
  sbr_pkg::result_t core_res;
  logic [7:0]       exp_id_r;
  logic [15:0]      rx_timeout_r;
  logic             out_load;
  logic             s1_fire;
  logic             in_fire;

  // Handshake: the result register frees up when empty or being taken
  assign out_load  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control flags and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      exp_id_r     <= 8'd0;
      rx_timeout_r <= sbr_pkg::RX_TIMEOUT_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sbr_pkg::REG_EXPECTED_ID) begin
          exp_id_r <= cfg_wdata[7:0];
        end else if (cfg_index == sbr_pkg::REG_RX_TIMEOUT) begin
          rx_timeout_r <= cfg_wdata[15:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action  <= sbr_pkg::action_t'(in_action);
      s1_item_r.rx_byte <= in_rx_byte;
    end
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  sbr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_fire   (s1_fire),
    .item        (s1_item_r),
    .expected_id (exp_id_r),
    .rx_timeout  (rx_timeout_r),
    .result      (core_res)
  );

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_res_r.event_res;
  assign out_payload_valid = out_res_r.payload_valid;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_index = out_res_r.payload_index;
  assign out_instruction   = out_res_r.instruction;
  assign out_packet_length = out_res_r.packet_length;

endmodule

`default_nettype wire

>>> hw/rtl/sbr_checker.sv
// ---------------------------------------------------------------------------
// sbr_checker
// Port-level checks on the packet receiver, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_stall,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_event_res,
  input  wire logic        out_payload_valid,
  input  wire logic [7:0]  out_payload_byte,
  input  wire logic [6:0]  out_payload_index,
  input  wire logic [7:0]  out_instruction,
  input  wire logic [15:0] out_packet_length
);

  logic [42:0] out_word;
  logic        payload_clear;
  logic        no_event;

  // Gather the result word and its simple conditions
  assign out_word      = {out_event_res, out_payload_valid, out_payload_byte,
                          out_payload_index, out_instruction, out_packet_length};
  assign payload_clear = (out_payload_byte == 8'd0) && (out_payload_index == 7'd0);
  assign no_event      = (out_event_res == sbr_pkg::EV_NONE);

  // A stalled result word holds
  `SBR_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && out_stall, ##1 (out_valid && $stable(out_word)))

  // Parameter bytes never carry an event
  `SBR_ASSERT_IMP(a_param_no_event, clk, rst_n, out_valid && out_payload_valid, no_event)

  // Non-parameter words carry zero payload
  `SBR_ASSERT_IMP(a_zero_payload, clk, rst_n, out_valid && !out_payload_valid, payload_clear)

  // Event codes stay within the defined set
  `SBR_ASSERT(a_event_range, clk, rst_n, !out_valid || out_event_res <= sbr_pkg::EV_TIMEOUT)

  // Stall only while a word waits in the input register and output is blocked
  `SBR_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind servo_bus_packet_receiver sbr_checker u_sbr_checker (.*);

`default_nettype wire
